### hw/rtl/r6r_pkg.sv
`timescale 1ns / 1ps

package r6r_pkg;

   localparam int MAX_DATA_DISKS = 32;
   localparam int OFFSET_WIDTH   = 12;

   localparam logic [1:0] REQ_DATA = 2'd0;
   localparam logic [1:0] REQ_P    = 2'd1;
   localparam logic [1:0] REQ_Q    = 2'd2;
   localparam logic [1:0] REQ_NOP  = 2'd3;

   localparam logic [1:0] MODE_FROM_P  = 2'd0;
   localparam logic [1:0] MODE_FROM_Q  = 2'd1;
   localparam logic [1:0] MODE_FROM_PQ = 2'd2;

   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_FIRST  = 2'd1;
   localparam logic [1:0] CSR_SECOND = 2'd2;
   localparam logic [1:0] CSR_COUNT  = 2'd3;

   localparam logic [2:0] SETTLE_CYCLES = 3'd4;

   typedef struct packed {
      logic [1:0]              kind;
      logic [4:0]              data_index;
      logic [OFFSET_WIDTH-1:0] byte_offset;
      logic [7:0]              byte_value;
   } req_item_type;

   typedef struct packed {
      logic [OFFSET_WIDTH-1:0] out_offset;
      logic [7:0]              rebuilt_byte;
      logic                    status;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] first;
      logic [4:0] second;
      logic [5:0] count;
   } cfg_type;

   typedef struct packed {
      logic [7:0] ginv_x;
      logic [7:0] coef_a;
      logic [7:0] coef_b;
   } coef_type;

   function automatic logic [7:0] gf_xtime(input logic [7:0] a);
      logic [7:0] r;
      r = {a[6:0], 1'b0};
      if (a[7]) begin
         r = r ^ 8'h1d;
      end
      return r;
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] t;
      r = 8'd0;
      t = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            r = r ^ t;
         end
         t = gf_xtime(t);
      end
      return r;
   endfunction

   function automatic logic [255:0][7:0] gf_exp_table();
      logic [255:0][7:0] t;
      logic [7:0]        r;
      r = 8'd1;
      for (int e = 0; e < 256; e++) begin
         t[e] = r;
         r = gf_xtime(r);
      end
      return t;
   endfunction

   localparam logic [255:0][7:0] GF_EXP = gf_exp_table();

   function automatic logic [255:0][7:0] gf_inv_table();
      logic [255:0][7:0] t;
      t = '0;
      for (int e = 0; e < 255; e++) begin
         t[GF_EXP[e]] = GF_EXP[(e == 0) ? 0 : 255 - e];
      end
      return t;
   endfunction

   localparam logic [255:0][7:0] GF_INV = gf_inv_table();

endpackage

### hw/rtl/r6r_coef.sv
`timescale 1ns / 1ps

module r6r_coef (
   input  logic               clock,
   input  r6r_pkg::cfg_type   cfg,
   output r6r_pkg::coef_type  coef
);

   logic [7:0] exp_x_in;
   logic [7:0] exp_d_in;

   logic [7:0] ginv_x_s1_ff, gy_s1_ff, d_s1_ff;
   logic [7:0] ginv_x_s2_ff, gy_s2_ff, invd_s2_ff;
   logic [7:0] ginv_x_s3_ff, gy_s3_ff, b_s3_ff;
   logic [7:0] ginv_x_s4_ff, a_s4_ff, b_s4_ff;

   always_comb begin
      exp_x_in = (cfg.first == 5'd0) ? 8'd0 : 8'd255 - {3'd0, cfg.first};
      if (cfg.second >= cfg.first) begin
         exp_d_in = {3'd0, cfg.second} - {3'd0, cfg.first};
      end else begin
         exp_d_in = {3'd0, cfg.second} + 8'd255 - {3'd0, cfg.first};
      end
   end

   always_ff @(posedge clock) begin
      ginv_x_s1_ff <= r6r_pkg::GF_EXP[exp_x_in];
      gy_s1_ff     <= r6r_pkg::GF_EXP[{3'd0, cfg.second}];
      d_s1_ff      <= r6r_pkg::GF_EXP[exp_d_in] ^ 8'd1;

      ginv_x_s2_ff <= ginv_x_s1_ff;
      gy_s2_ff     <= gy_s1_ff;
      invd_s2_ff   <= r6r_pkg::GF_INV[d_s1_ff];

      ginv_x_s3_ff <= ginv_x_s2_ff;
      gy_s3_ff     <= gy_s2_ff;
      b_s3_ff      <= r6r_pkg::gf_mul(ginv_x_s2_ff, invd_s2_ff);

      ginv_x_s4_ff <= ginv_x_s3_ff;
      b_s4_ff      <= b_s3_ff;
      a_s4_ff      <= r6r_pkg::gf_mul(gy_s3_ff, b_s3_ff);
   end

   assign coef.ginv_x = ginv_x_s4_ff;
   assign coef.coef_a = a_s4_ff;
   assign coef.coef_b = b_s4_ff;

endmodule

### hw/rtl/r6r_accum.sv
`timescale 1ns / 1ps

module r6r_accum #(
   parameter int BLOCK_BYTES = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_accept,
   input  r6r_pkg::req_item_type  in_item,
   input  r6r_pkg::cfg_type       cfg,
   input  r6r_pkg::coef_type      coef,
   output logic                   clr_busy,
   output logic                   s1_busy,
   output logic                   push,
   output r6r_pkg::rsp_item_type  push_item
);

   localparam int FULL_DEPTH = 1 << r6r_pkg::OFFSET_WIDTH;
   localparam int DEPTH      = (BLOCK_BYTES < FULL_DEPTH) ? BLOCK_BYTES : FULL_DEPTH;
   localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0] p_mem [DEPTH];
   logic [7:0] q_mem [DEPTH];

   logic                  clr_busy_ff;
   logic [AW-1:0]         clr_addr_ff;
   logic                  s1_valid_ff;
   r6r_pkg::req_item_type s1_item_ff;
   logic [7:0]            s1_gd_ff;
   logic [7:0]            p_rd_ff, q_rd_ff;
   logic                  fwd_ff;
   logic [7:0]            fwd_p_ff, fwd_q_ff;
   logic                  push_ff;
   r6r_pkg::rsp_item_type push_item_ff;

   logic [AW-1:0]         in_addr;
   logic [AW-1:0]         s1_addr;
   logic [7:0]            cur_p, cur_q, q_par;
   logic                  off_ok, x_ok, y_ok, d_ok;
   logic                  wr_in;
   logic [7:0]            new_p_in, new_q_in;
   logic                  res_in;
   logic                  st_in;
   logic [7:0]            byte_in;

   assign in_addr = in_item.byte_offset[AW-1:0];
   assign s1_addr = s1_item_ff.byte_offset[AW-1:0];
   assign cur_p   = fwd_ff ? fwd_p_ff : p_rd_ff;
   assign cur_q   = fwd_ff ? fwd_q_ff : q_rd_ff;
   assign q_par   = cur_q ^ s1_item_ff.byte_value;

   always_comb begin
      off_ok = 32'(s1_item_ff.byte_offset) < 32'(BLOCK_BYTES);
      x_ok   = ({1'b0, cfg.first} < cfg.count) && (32'(cfg.first) < r6r_pkg::MAX_DATA_DISKS);
      y_ok   = ({1'b0, cfg.second} < cfg.count) &&
               (32'(cfg.second) < r6r_pkg::MAX_DATA_DISKS);
      d_ok   = ({1'b0, s1_item_ff.data_index} < cfg.count) &&
               (32'(s1_item_ff.data_index) < r6r_pkg::MAX_DATA_DISKS) &&
               (s1_item_ff.data_index != cfg.first) &&
               !(cfg.mode == r6r_pkg::MODE_FROM_PQ && s1_item_ff.data_index == cfg.second);

      wr_in    = 1'b0;
      new_p_in = 8'd0;
      new_q_in = 8'd0;
      res_in   = 1'b0;
      st_in    = 1'b0;
      byte_in  = 8'd0;

      if (s1_valid_ff && s1_item_ff.kind != r6r_pkg::REQ_NOP) begin
         if (!off_ok) begin
            res_in = 1'b1;
            st_in  = 1'b1;
         end else if (s1_item_ff.kind == r6r_pkg::REQ_DATA) begin
            if (d_ok) begin
               wr_in    = 1'b1;
               new_p_in = cur_p ^ s1_item_ff.byte_value;
               new_q_in = cur_q ^ r6r_pkg::gf_mul(s1_item_ff.byte_value, s1_gd_ff);
            end else begin
               res_in = 1'b1;
               st_in  = 1'b1;
            end
         end else if (cfg.mode == r6r_pkg::MODE_FROM_P && s1_item_ff.kind == r6r_pkg::REQ_Q) begin
            wr_in = 1'b0;
         end else if (cfg.mode == r6r_pkg::MODE_FROM_Q && s1_item_ff.kind == r6r_pkg::REQ_P) begin
            wr_in = 1'b0;
         end else if (cfg.mode == r6r_pkg::MODE_FROM_PQ &&
                      s1_item_ff.kind == r6r_pkg::REQ_P) begin
            wr_in    = 1'b1;
            new_p_in = cur_p ^ s1_item_ff.byte_value;
            new_q_in = cur_q;
         end else begin
            wr_in  = 1'b1;
            res_in = 1'b1;
            case (cfg.mode)
               r6r_pkg::MODE_FROM_P: begin
                  st_in   = !x_ok;
                  byte_in = cur_p ^ s1_item_ff.byte_value;
               end
               r6r_pkg::MODE_FROM_Q: begin
                  st_in   = !x_ok;
                  byte_in = r6r_pkg::gf_mul(q_par, coef.ginv_x);
               end
               r6r_pkg::MODE_FROM_PQ: begin
                  st_in   = !(x_ok && y_ok && cfg.first != cfg.second);
                  byte_in = r6r_pkg::gf_mul(cur_p, coef.coef_a) ^
                            r6r_pkg::gf_mul(q_par, coef.coef_b);
               end
               default: begin
                  st_in = 1'b1;
               end
            endcase
            if (st_in) begin
               byte_in = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         p_mem[clr_addr_ff] <= 8'd0;
         q_mem[clr_addr_ff] <= 8'd0;
      end else if (wr_in) begin
         p_mem[s1_addr] <= new_p_in;
         q_mem[s1_addr] <= new_q_in;
      end
      p_rd_ff <= p_mem[in_addr];
      q_rd_ff <= q_mem[in_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         push_ff     <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         s1_valid_ff <= in_accept;
         push_ff     <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_item_ff <= in_item;
         s1_gd_ff   <= r6r_pkg::GF_EXP[{3'd0, in_item.data_index}];
         fwd_ff     <= wr_in && (s1_addr == in_addr);
         fwd_p_ff   <= new_p_in;
         fwd_q_ff   <= new_q_in;
      end
      push_item_ff.out_offset   <= s1_item_ff.byte_offset;
      push_item_ff.rebuilt_byte <= byte_in;
      push_item_ff.status       <= st_in;
   end

   assign clr_busy  = clr_busy_ff;
   assign s1_busy   = s1_valid_ff | push_ff;
   assign push      = push_ff;
   assign push_item = push_item_ff;

endmodule

### hw/rtl/r6r_rsp_fifo.sv
`timescale 1ns / 1ps

module r6r_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  r6r_pkg::rsp_item_type  push_item,
   input  logic                   pop,
   output logic                   not_empty,
   output logic [2:0]             count,
   output r6r_pkg::rsp_item_type  head
);

   r6r_pkg::rsp_item_type slot_ff [4];
   logic [1:0]            wr_ptr_ff, rd_ptr_ff;
   logic [2:0]            count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + {2'd0, push} - {2'd0, pop};
      end
   end

   assign not_empty = count_ff != 3'd0;
   assign count     = count_ff;
   assign head      = slot_ff[rd_ptr_ff];

endmodule

### hw/rtl/raid6_two_erasure_rebuild_core.sv
`timescale 1ns / 1ps

// channel   signals                                          direction
// req       req_valid/ready, req_type, req_data_index,       in
//           req_byte_offset, req_byte_value
// rsp       rsp_valid/ready, rsp_out_offset,                 out
//           rsp_rebuilt_byte, rsp_status
// csr       csr_valid/ready, csr_index, csr_data             in
//
// One word per cycle while rsp_ready stays high and no RAM clear or csr settle runs;
// a result passes the s1 register, the push register and the result queue to leave.
// The accumulator RAM read is registered as a word is taken; GF multiply and write back
// are in s1. After reset all min(BLOCK_BYTES, 4096) RAM entries are zeroed, req_ready low.
// After each csr write req_ready is low while coefficients settle. A four-word result
// queue absorbs rsp stalls; req_ready drops once queued words plus a busy pipe reach three.

module raid6_two_erasure_rebuild_core #(
   parameter int BLOCK_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [4:0]  req_data_index,
   input  logic [11:0] req_byte_offset,
   input  logic [7:0]  req_byte_value,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_out_offset,
   output logic [7:0]  rsp_rebuilt_byte,
   output logic        rsp_status,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_data
);

   r6r_pkg::cfg_type      cfg_ff;
   logic [2:0]            settle_ff;
   r6r_pkg::coef_type     coef;
   r6r_pkg::req_item_type in_item;
   r6r_pkg::rsp_item_type push_item;
   r6r_pkg::rsp_item_type head;
   logic                  in_accept;
   logic                  csr_write;
   logic                  clr_busy;
   logic                  s1_busy;
   logic                  push;
   logic                  pop;
   logic [2:0]            fifo_count;
   logic [3:0]            in_flight;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= r6r_pkg::MODE_FROM_P;
         cfg_ff.first  <= 5'd0;
         cfg_ff.second <= 5'd1;
         cfg_ff.count  <= 6'd2;
         settle_ff     <= r6r_pkg::SETTLE_CYCLES;
      end else begin
         if (csr_write) begin
            settle_ff <= r6r_pkg::SETTLE_CYCLES;
            unique case (csr_index)
               r6r_pkg::CSR_MODE:   cfg_ff.mode   <= csr_data[1:0];
               r6r_pkg::CSR_FIRST:  cfg_ff.first  <= csr_data[4:0];
               r6r_pkg::CSR_SECOND: cfg_ff.second <= csr_data[4:0];
               r6r_pkg::CSR_COUNT:  cfg_ff.count  <= csr_data;
               default: ;
            endcase
         end else if (settle_ff != 3'd0) begin
            settle_ff <= settle_ff - 3'd1;
         end
      end
   end

   assign in_flight = {3'd0, s1_busy} + {1'b0, fifo_count};
   assign req_ready = !clr_busy && (settle_ff == 3'd0) && (in_flight < 4'd3);
   assign in_accept = req_valid & req_ready;

   assign in_item.kind        = req_type;
   assign in_item.data_index  = req_data_index;
   assign in_item.byte_offset = req_byte_offset;
   assign in_item.byte_value  = req_byte_value;

   r6r_coef u_coef (
      .clock (clock),
      .cfg   (cfg_ff),
      .coef  (coef)
   );

   r6r_accum #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_item   (in_item),
      .cfg       (cfg_ff),
      .coef      (coef),
      .clr_busy  (clr_busy),
      .s1_busy   (s1_busy),
      .push      (push),
      .push_item (push_item)
   );

   assign pop = rsp_valid & rsp_ready;

   r6r_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .not_empty (rsp_valid),
      .count     (fifo_count),
      .head      (head)
   );

   assign rsp_out_offset   = head.out_offset;
   assign rsp_rebuilt_byte = head.rebuilt_byte;
   assign rsp_status       = head.status;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import r6r_pkg::*;

   localparam int BLOCK_SIZE = 4096;
   localparam int LONG_HOLD = 300;
   localparam logic [1:0] REQ_NONE = 2'd3;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_type = 2'd0;
   logic [4:0] req_data_index = 5'd0;
   logic [11:0] req_byte_offset = 12'd0;
   logic [7:0] req_byte_value = 8'd0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [11:0] rsp_out_offset;
   logic [7:0] rsp_rebuilt_byte;
   logic rsp_status;

   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = 2'd0;
   logic [5:0] csr_data = 6'd0;

   raid6_two_erasure_rebuild_core #(
      .BLOCK_BYTES(BLOCK_SIZE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_data_index(req_data_index),
      .req_byte_offset(req_byte_offset),
      .req_byte_value(req_byte_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_offset(rsp_out_offset),
      .rsp_rebuilt_byte(rsp_rebuilt_byte),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // shadow of the rebuild state
   logic [7:0] p_sum [BLOCK_SIZE];
   logic [7:0] q_sum [BLOCK_SIZE];
   logic [1:0] cfg_mode = MODE_FROM_P;
   logic [4:0] cfg_first = 5'd0;
   logic [4:0] cfg_second = 5'd1;
   logic [5:0] cfg_count = 6'd2;

   req_item_type pending_words [$];
   rsp_item_type rebuilt_due [$];
   int word_sent = 0;
   int word_taken = 0;
   int word_count = 0;
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1500000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [7:0] gf256_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] sh;
      acc = 8'h00;
      sh = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ sh;
         end
         sh = {sh[6:0], 1'b0} ^ (sh[7] ? 8'h1d : 8'h00);
      end
      return acc;
   endfunction

   // g^e, exponent mod 255
   function automatic logic [7:0] gen_power(input int unsigned e);
      logic [7:0] r;
      r = 8'h01;
      for (int unsigned k = 0; k < e % 255; k++) begin
         r = gf256_times(r, 8'h02);
      end
      return r;
   endfunction

   function automatic logic [7:0] gf256_inverse(input logic [7:0] a);
      logic [7:0] r;
      r = 8'h01;
      for (int k = 0; k < 254; k++) begin
         r = gf256_times(r, a);
      end
      return r;
   endfunction

   task automatic rebuild_predict(input logic [1:0] kind, input logic [4:0] idx,
                                  input logic [11:0] off, input logic [7:0] val);
      rsp_item_type exp_word;
      logic [7:0] coef_a;
      logic [7:0] coef_b;
      logic [7:0] q_syn;
      logic first_ok;
      logic second_ok;
      exp_word.out_offset = off;
      exp_word.rebuilt_byte = 8'h00;
      exp_word.status = 1'b1;
      first_ok = (cfg_first < cfg_count) && (cfg_first < MAX_DATA_DISKS);
      second_ok = (cfg_second < cfg_count) && (cfg_second < MAX_DATA_DISKS);
      if (kind == REQ_NONE) begin
      end else if (kind == REQ_DATA) begin
         if (idx >= cfg_count || idx == cfg_first ||
             (cfg_mode == MODE_FROM_PQ && idx == cfg_second)) begin
            rebuilt_due.push_back(exp_word);
         end else begin
            p_sum[off] = p_sum[off] ^ val;
            q_sum[off] = q_sum[off] ^ gf256_times(val, gen_power(idx));
         end
      end else if ((cfg_mode == MODE_FROM_P && kind == REQ_Q) ||
                   (cfg_mode == MODE_FROM_Q && kind == REQ_P)) begin
         // unused parity
      end else if (cfg_mode == MODE_FROM_PQ && kind == REQ_P) begin
         p_sum[off] = p_sum[off] ^ val;
      end else begin
         q_syn = q_sum[off] ^ val;
         case (cfg_mode)
            MODE_FROM_P: begin
               if (first_ok) begin
                  exp_word.rebuilt_byte = p_sum[off] ^ val;
                  exp_word.status = 1'b0;
               end
            end
            MODE_FROM_Q: begin
               if (first_ok) begin
                  exp_word.rebuilt_byte = gf256_times(q_syn, gen_power(255 - cfg_first));
                  exp_word.status = 1'b0;
               end
            end
            MODE_FROM_PQ: begin
               if (first_ok && second_ok && cfg_first != cfg_second) begin
                  coef_b = gf256_times(gen_power(255 - cfg_first),
                     gf256_inverse(gen_power(cfg_second + 255 - cfg_first) ^ 8'h01));
                  coef_a = gf256_times(gen_power(cfg_second), coef_b);
                  exp_word.rebuilt_byte = gf256_times(p_sum[off], coef_a) ^
                                          gf256_times(q_syn, coef_b);
                  exp_word.status = 1'b0;
               end
            end
            default: begin
            end
         endcase
         p_sum[off] = 8'h00;
         q_sum[off] = 8'h00;
         rebuilt_due.push_back(exp_word);
      end
   endtask

   always @(negedge clock) begin : driver
      req_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (word_sent == word_taken) begin
         if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_words.pop_front();
            req_valid <= 1'b1;
            req_type <= nxt.kind;
            req_data_index <= nxt.data_index;
            req_byte_offset <= nxt.byte_offset;
            req_byte_value <= nxt.byte_value;
            word_sent++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (hold_served != hold_asked) begin
         hold_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      rsp_item_type exp_word;
      if (!reset) begin
         if (req_valid && req_ready) begin
            word_taken++;
            rebuild_predict(req_type, req_data_index, req_byte_offset, req_byte_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (rebuilt_due.size() == 0) begin
               $display("%0t unexpected word: offset %h byte %h status %b", $time,
                        rsp_out_offset, rsp_rebuilt_byte, rsp_status);
               mismatch_count++;
            end else begin
               exp_word = rebuilt_due.pop_front();
               if (rsp_out_offset !== exp_word.out_offset) begin
                  $display("%0t out_offset: expected %h actual %h", $time,
                           exp_word.out_offset, rsp_out_offset);
                  mismatch_count++;
               end
               if (rsp_rebuilt_byte !== exp_word.rebuilt_byte) begin
                  $display("%0t rebuilt_byte at %h: expected %h actual %h", $time,
                           exp_word.out_offset, exp_word.rebuilt_byte, rsp_rebuilt_byte);
                  mismatch_count++;
               end
               if (rsp_status !== exp_word.status) begin
                  $display("%0t status at %h: expected %b actual %b", $time,
                           exp_word.out_offset, exp_word.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
      end
   end

   task automatic push_word(input logic [1:0] kind, input logic [4:0] idx,
                            input logic [11:0] off, input logic [7:0] val, input int noise_pct);
      req_item_type w;
      if ($urandom_range(0, 99) < noise_pct) begin
         w.kind = $urandom_range(0, 3);
         w.data_index = $urandom_range(0, 31);
         w.byte_offset = off;
         w.byte_value = $urandom_range(0, 255);
         pending_words.push_back(w);
         if (w.kind != REQ_NONE) word_count++;
      end
      w.kind = kind;
      w.data_index = idx;
      w.byte_offset = off;
      w.byte_value = val;
      pending_words.push_back(w);
      if (kind != REQ_NONE) word_count++;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [5:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MODE: cfg_mode = val[1:0];
         CSR_FIRST: cfg_first = val[4:0];
         CSR_SECOND: cfg_second = val[4:0];
         default: cfg_count = val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [5:0] mode_w, input logic [5:0] first_w,
                             input logic [5:0] second_w, input logic [5:0] count_w);
      csr_write(CSR_MODE, mode_w);
      csr_write(CSR_FIRST, first_w);
      csr_write(CSR_SECOND, second_w);
      csr_write(CSR_COUNT, count_w);
      @(posedge clock);
   endtask

   // wait for every word taken and every result back, then let the pipe drain
   task automatic settle();
      while (pending_words.size() != 0 || word_sent != word_taken) @(negedge clock);
      while (rebuilt_due.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   // disk-major stripes over a few offsets, parity last
   task automatic queue_stripes(input int n_off, input int noise_pct);
      logic [11:0] offs [$];
      int disks;
      logic swap_pq;
      logic use_p;
      logic use_q;
      disks = (cfg_count > 32) ? 32 : cfg_count;
      for (int k = 0; k < n_off; k++) begin
         offs.push_back($urandom_range(0, 4095));
      end
      for (int d = 0; d < disks; d++) begin
         if (d != cfg_first && !(cfg_mode == MODE_FROM_PQ && d == cfg_second)) begin
            foreach (offs[k]) push_word(REQ_DATA, d, offs[k], $urandom_range(0, 255), noise_pct);
         end
      end
      swap_pq = (cfg_mode == MODE_FROM_PQ) && ($urandom_range(0, 9) == 0);
      use_p = (cfg_mode != MODE_FROM_Q) || ($urandom_range(0, 5) == 0);
      use_q = (cfg_mode != MODE_FROM_P) || ($urandom_range(0, 5) == 0);
      if (use_q && swap_pq) begin
         foreach (offs[k]) push_word(REQ_Q, 0, offs[k], $urandom_range(0, 255), noise_pct);
      end
      if (use_p) begin
         foreach (offs[k]) push_word(REQ_P, $urandom_range(0, 31), offs[k],
                                     $urandom_range(0, 255), noise_pct);
      end
      if (use_q && !swap_pq) begin
         foreach (offs[k]) push_word(REQ_Q, $urandom_range(0, 31), offs[k],
                                     $urandom_range(0, 255), noise_pct);
      end
   endtask

   initial begin
      int phase;
      int disks_cap;
      logic [5:0] m_w;
      logic [5:0] f_w;
      logic [5:0] s_w;
      logic [5:0] c_w;
      for (int k = 0; k < BLOCK_SIZE; k++) begin
         p_sum[k] = 8'h00;
         q_sum[k] = 8'h00;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: rebuild from P, disk 0 lost, two data disks
      push_word(REQ_DATA, 1, 12'd0, 8'hff, 0);
      push_word(REQ_P, 0, 12'd0, 8'h00, 0);
      push_word(REQ_DATA, 1, 12'd4095, 8'h00, 0);
      push_word(REQ_P, 31, 12'd4095, 8'hff, 0);
      push_word(REQ_Q, 0, 12'd4095, 8'h12, 0);
      push_word(REQ_NONE, 31, 12'd100, 8'h55, 0);
      push_word(REQ_DATA, 0, 12'd100, 8'h01, 0);
      push_word(REQ_DATA, 2, 12'd100, 8'h01, 0);
      push_word(REQ_DATA, 31, 12'd4095, 8'hff, 0);
      settle();

      set_config(MODE_FROM_Q, 6'd31, 6'd0, 6'd32);
      push_word(REQ_DATA, 30, 12'd7, 8'h80, 0);
      push_word(REQ_DATA, 0, 12'd7, 8'h01, 0);
      push_word(REQ_Q, 0, 12'd7, 8'h5a, 0);
      push_word(REQ_P, 0, 12'd7, 8'h3c, 0);
      push_word(REQ_DATA, 31, 12'd8, 8'h99, 0);
      settle();

      set_config(MODE_FROM_PQ, 6'd3, 6'd30, 6'd32);
      push_word(REQ_DATA, 0, 12'd9, 8'hab, 0);
      push_word(REQ_DATA, 31, 12'd9, 8'hcd, 0);
      push_word(REQ_P, 0, 12'd9, 8'h11, 0);
      push_word(REQ_Q, 0, 12'd9, 8'h22, 0);
      // Q ahead of P: P lands in the cleared offset
      push_word(REQ_Q, 0, 12'd10, 8'h33, 0);
      push_word(REQ_P, 0, 12'd10, 8'h44, 0);
      push_word(REQ_DATA, 30, 12'd10, 8'h66, 0);
      settle();

      set_config(MODE_FROM_PQ, 6'd4, 6'd4, 6'd6);
      push_word(REQ_Q, 0, 12'd11, 8'h01, 0);
      settle();

      set_config(MODE_SPARE, 6'd0, 6'd1, 6'd2);
      push_word(REQ_DATA, 1, 12'd12, 8'h77, 0);
      push_word(REQ_P, 0, 12'd12, 8'h10, 0);
      push_word(REQ_Q, 0, 12'd12, 8'h20, 0);
      settle();

      set_config(MODE_FROM_P, 6'd5, 6'd1, 6'd0);
      push_word(REQ_P, 0, 12'd13, 8'h01, 0);
      settle();

      // long rsp stall with P-only stripes so the input backs up
      set_config(MODE_FROM_P, 6'd0, 6'd1, 6'd1);
      hold_asked++;
      for (int k = 0; k < 40; k++) begin
         push_word(REQ_P, $urandom_range(0, 31), $urandom_range(0, 4095),
                   $urandom_range(0, 255), 0);
      end
      settle();

      phase = 0;
      while (word_count < 560) begin
         case ($urandom_range(0, 9))
            0, 1, 2: m_w = MODE_FROM_P;
            3, 4, 5: m_w = MODE_FROM_Q;
            9: m_w = MODE_SPARE;
            default: m_w = MODE_FROM_PQ;
         endcase
         if ($urandom_range(0, 3) == 0) m_w[5:2] = $urandom_range(0, 15);
         case ($urandom_range(0, 15))
            0: c_w = $urandom_range(0, 63);
            1: c_w = 6'd32;
            default: c_w = $urandom_range(2, 8);
         endcase
         disks_cap = (c_w > 32) ? 32 : c_w;
         if (disks_cap == 0 || $urandom_range(0, 9) == 0) begin
            f_w = $urandom_range(0, 31);
         end else begin
            f_w = $urandom_range(0, disks_cap - 1);
         end
         if (disks_cap < 2 || $urandom_range(0, 9) == 0) begin
            s_w = $urandom_range(0, 31);
         end else begin
            s_w = (f_w + $urandom_range(1, disks_cap - 1)) % disks_cap;
         end
         if ($urandom_range(0, 3) == 0) f_w[5] = 1'b1;
         if ($urandom_range(0, 3) == 0) s_w[5] = 1'b1;
         set_config(m_w, f_w, s_w, c_w);
         case (phase % 5)
            1: begin send_idle_pct = 84; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 84; end
            3: begin send_idle_pct = 23; recv_stall_pct = 23; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         repeat ($urandom_range(1, 3)) begin
            queue_stripes((disks_cap > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6),
                          (phase % 3 == 0) ? 0 : 6);
         end
         settle();
         phase++;
      end

      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
